// ===== rtl/core/dops_pkg.sv =====
// Shared command codes and controller/datapath status type of the slot scheduler.
package dops_pkg;

    // Commands issued by the controller to the datapath, one per cycle.
    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NONE      = 4'd0;
    localparam t_cmd CMD_ACCEPT    = 4'd1;
    localparam t_cmd CMD_REG       = 4'd2;
    localparam t_cmd CMD_SET       = 4'd3;
    localparam t_cmd CMD_OTA       = 4'd4;
    localparam t_cmd CMD_WALK_STEP = 4'd5;
    localparam t_cmd CMD_BUB_STEP  = 4'd6;
    localparam t_cmd CMD_FINISH    = 4'd7;
    localparam t_cmd CMD_SORT_KEY  = 4'd8;
    localparam t_cmd CMD_SORT_STEP = 4'd9;
    localparam t_cmd CMD_REM_STEP  = 4'd10;
    localparam t_cmd CMD_REM_END   = 4'd11;
    localparam t_cmd CMD_WAKE_STEP = 4'd12;
    localparam t_cmd CMD_STATUS    = 4'd13;

    // Request codes.
    localparam logic [1:0] REQ_POLL = 2'd0;
    localparam logic [1:0] REQ_REG  = 2'd1;
    localparam logic [1:0] REQ_SET  = 2'd2;
    localparam logic [1:0] REQ_WAKE = 2'd3;

    // Flag bit positions of a slot.
    localparam int FLAG_LOOP   = 0;
    localparam int FLAG_WIFI   = 1;
    localparam int FLAG_NTP    = 2;
    localparam int FLAG_UPLOAD = 3;

    localparam logic [31:0] WAKE_CAP = 32'd1000;
    localparam logic [31:0] DEFER_MS = 32'd1;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       early;
        logic       ota;
        logic       full;
        logic       bad;
        logic       reg_append;
        logic       rem_need;
        logic       walk_go;
        logic       walk_fire;
        logic       bub_swap;
        logic       sort_more;
        logic       ins_shift;
        logic       list_more;
        logic       out_free;
    } t_status;

    // Wrap-safe time order.
    function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic time_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

// ===== rtl/core/due_order_periodic_scheduler.sv =====
// Periodic slot scheduler with an earliest-due list: top level.
// A refused request, an early poll or an update-time poll passes through dispatch and status
// only, its status transaction registered from the status state; a walking poll adds walk
// steps, each followed by bubble swaps (at most 4*SLOTS steps); a re-sort adds a key step
// plus shifts per key; removal and wake-all step once through each list entry.
// One request is handled at a time, output stalls hold the sequencer; reset (synchronous, active
// low) clears all slot tables, counts and the wake time.
module due_order_periodic_scheduler
    import dops_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now[31:0], slot[35:32], interval[52:36], wifi_ok, ntp_ok, paused, ota_active,
    // needs_wifi, needs_ntp, is_upload, loop_en[60], zeros above
    input  logic [63:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fired_slot[3:0], ok[4], next_wake[36:5], zeros above
    output logic [39:0] m_axis_tdata,
    // kind[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    t_cmd    cmd;
    t_status st;

    dops_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_st     (st),
        .o_cmd    (cmd)
    );

    dops_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_st     (st),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/dops_ctrl.sv =====
// Sequencing state machine of the slot scheduler.
module dops_ctrl
    import dops_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tvalid,
    output logic    o_tready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_BUBBLE = 4'd3;
    localparam logic [3:0] S_SORT_K = 4'd4;
    localparam logic [3:0] S_SORT_I = 4'd5;
    localparam logic [3:0] S_REM    = 4'd6;
    localparam logic [3:0] S_WAKE   = 4'd7;
    localparam logic [3:0] S_STATUS = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_tready = (r_state == S_IDLE);

    // Next state and command.
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_tvalid) begin
                    o_cmd   = CMD_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_st.req_type)
                    REQ_POLL: begin
                        if (i_st.early) begin
                            n_state = S_STATUS;
                        end else if (i_st.ota) begin
                            o_cmd   = CMD_OTA;
                            n_state = S_STATUS;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    REQ_REG: begin
                        if (i_st.full) begin
                            n_state = S_STATUS;
                        end else begin
                            o_cmd   = CMD_REG;
                            n_state = i_st.reg_append ? S_SORT_K : S_STATUS;
                        end
                    end
                    REQ_SET: begin
                        if (i_st.bad) begin
                            n_state = S_STATUS;
                        end else begin
                            o_cmd   = CMD_SET;
                            n_state = i_st.rem_need ? S_REM : S_SORT_K;
                        end
                    end
                    default: n_state = S_WAKE;
                endcase
            end
            S_WALK: begin
                if (i_st.walk_go) begin
                    if (!i_st.walk_fire || i_st.out_free) begin
                        o_cmd   = CMD_WALK_STEP;
                        n_state = S_BUBBLE;
                    end
                end else begin
                    o_cmd   = CMD_FINISH;
                    n_state = S_STATUS;
                end
            end
            S_BUBBLE: begin
                o_cmd = CMD_BUB_STEP;
                if (!i_st.bub_swap) n_state = S_WALK;
            end
            S_SORT_K: begin
                if (i_st.sort_more) begin
                    o_cmd   = CMD_SORT_KEY;
                    n_state = S_SORT_I;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_SORT_I: begin
                o_cmd = CMD_SORT_STEP;
                if (!i_st.ins_shift) n_state = S_SORT_K;
            end
            S_REM: begin
                if (i_st.list_more) begin
                    o_cmd = CMD_REM_STEP;
                end else begin
                    o_cmd   = CMD_REM_END;
                    n_state = S_SORT_K;
                end
            end
            S_WAKE: begin
                if (i_st.list_more) o_cmd = CMD_WAKE_STEP;
                else n_state = S_STATUS;
            end
            S_STATUS: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_STATUS;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/dops_dp.sv =====
// Slot tables, due list, walk counters and output register of the slot scheduler.
module dops_dp
    import dops_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_tdata,
    input  logic [1:0]  i_tuser,
    output t_status     o_st,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [39:0] o_tdata,
    output logic        o_tuser,
    output logic        o_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = $clog2(4 * SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [TW-1:0] STEPS_C = TW'(4 * SLOTS);

    // Slot tables and due list.
    logic [15:0]   r_period  [SLOTS];
    logic [31:0]   r_last    [SLOTS];
    logic [31:0]   r_due     [SLOTS];
    logic [3:0]    r_flags   [SLOTS];
    logic [SW-1:0] r_list    [SLOTS];
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_used;
    logic [31:0]   r_wake;

    // Latched request.
    logic [1:0]  r_req;
    logic [31:0] r_now;
    logic [3:0]  r_sl;
    logic [16:0] r_ival;
    logic [7:0]  r_bits;
    logic        r_ok;

    // Walk and sort counters.
    logic [CW-1:0] r_ia;
    logic [CW-1:0] r_ib;
    logic [TW-1:0] r_steps;
    logic [CW-1:0] r_nfire;
    logic          r_found;
    logic [SW-1:0] r_key;
    logic [31:0]   r_keydue;

    // Output register.
    logic        r_ovalid;
    logic [3:0]  r_oslot;
    logic        r_ook;
    logic [31:0] r_owake;
    logic        r_okind;

    logic          neg;
    logic [15:0]   mag;
    logic [SW-1:0] sl_idx;
    logic [SW-1:0] a_idx;
    logic [SW-1:0] cur_idx;
    logic [SW-1:0] nxt_idx;
    logic [SW-1:0] bm1_idx;
    logic [SW-1:0] front;
    logic          gated;
    logic [31:0]   fallback;
    logic [31:0]   next_w;

    assign neg      = r_ival[16];
    assign mag      = neg ? 16'd0 : r_ival[15:0];
    assign sl_idx   = SW'(r_sl);
    assign a_idx    = r_ia[SW-1:0];
    assign cur_idx  = r_ib[SW-1:0];
    assign nxt_idx  = SW'(r_ib + 1'b1);
    assign bm1_idx  = SW'(r_ib - 1'b1);
    assign front    = r_list[a_idx];
    assign gated    = (r_flags[front][FLAG_WIFI] && !r_bits[0])
                   || (r_flags[front][FLAG_NTP] && !r_bits[1])
                   || (r_bits[2] && r_flags[front][FLAG_UPLOAD]);
    assign fallback = r_now + WAKE_CAP;

    // Wake time after a walk, capped at now plus the cap.
    always_comb begin
        next_w = (r_len != '0) ? r_due[r_list[0]] : fallback;
        if (time_after(next_w, fallback)) next_w = fallback;
    end

    // Status towards the controller.
    always_comb begin
        o_st.req_type   = r_req;
        o_st.early      = time_before(r_now, r_wake);
        o_st.ota        = r_bits[3];
        o_st.full       = (r_used >= SLOTS_C);
        o_st.bad        = ({28'd0, r_sl} >= 32'(r_used)) || ({28'd0, r_sl} >= 32'(SLOTS));
        o_st.reg_append = r_bits[4] && (r_len < SLOTS_C);
        o_st.rem_need   = r_flags[sl_idx][FLAG_LOOP] && neg;
        o_st.walk_go    = (r_ia < r_len) && (r_steps < STEPS_C) && (r_nfire < SLOTS_C)
                       && !time_before(r_now, r_due[front]);
        o_st.walk_fire  = !gated;
        o_st.bub_swap   = ((r_ib + 1'b1) < r_len)
                       && time_after(r_due[r_list[cur_idx]], r_due[r_list[nxt_idx]]);
        o_st.sort_more  = (r_ia < r_len);
        o_st.ins_shift  = (r_ib != '0) && time_after(r_due[r_list[bm1_idx]], r_keydue);
        o_st.list_more  = (r_ia < r_len);
        o_st.out_free   = !r_ovalid || i_tready;
    end

    // Slot tables, with reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_period[i] <= '0;
                r_last[i]   <= '0;
                r_due[i]    <= '0;
                r_flags[i]  <= '0;
            end
            r_len  <= '0;
            r_used <= '0;
            r_wake <= '0;
        end else begin
            unique case (i_cmd)
                CMD_OTA: r_wake <= r_now;
                CMD_REG: begin
                    r_period[r_used[SW-1:0]] <= mag;
                    r_last[r_used[SW-1:0]]   <= '0;
                    r_due[r_used[SW-1:0]]    <= '0;
                    r_flags[r_used[SW-1:0]]  <= r_bits[7:4];
                    if (o_st.reg_append) r_len <= r_len + 1'b1;
                    r_used <= r_used + 1'b1;
                    r_wake <= r_now;
                end
                CMD_SET: begin
                    if (!neg) begin
                        r_flags[sl_idx][FLAG_LOOP] <= 1'b1;
                        r_period[sl_idx] <= mag;
                        r_due[sl_idx]    <= r_last[sl_idx] + {16'd0, mag};
                        if (!r_flags[sl_idx][FLAG_LOOP] && r_len < SLOTS_C)
                            r_len <= r_len + 1'b1;
                    end else begin
                        r_flags[sl_idx][FLAG_LOOP] <= 1'b0;
                    end
                    r_wake <= r_now;
                end
                CMD_WALK_STEP: begin
                    if (gated) begin
                        r_due[front] <= r_now + DEFER_MS;
                    end else begin
                        r_last[front] <= r_now;
                        r_due[front]  <= r_now + {16'd0, r_period[front]};
                    end
                end
                CMD_FINISH:    r_wake <= next_w;
                CMD_REM_END:   if (r_found) r_len <= r_len - 1'b1;
                CMD_WAKE_STEP: begin
                    r_due[r_list[a_idx]] <= r_now;
                    r_wake <= r_now;
                end
                default: ;
            endcase
            // Wake-all on an empty list still moves the wake time.
            if (i_cmd == CMD_NONE && r_req == REQ_WAKE && !o_st.list_more)
                r_wake <= r_now;
        end
    end

    // Due list, no reset: only entries below the length are read.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_REG: if (o_st.reg_append) r_list[r_len[SW-1:0]] <= r_used[SW-1:0];
            CMD_SET: begin
                if (!neg && !r_flags[sl_idx][FLAG_LOOP] && r_len < SLOTS_C)
                    r_list[r_len[SW-1:0]] <= sl_idx;
            end
            CMD_BUB_STEP: begin
                if (o_st.bub_swap) begin
                    r_list[cur_idx] <= r_list[nxt_idx];
                    r_list[nxt_idx] <= r_list[cur_idx];
                end
            end
            CMD_SORT_STEP: begin
                if (o_st.ins_shift) r_list[cur_idx] <= r_list[bm1_idx];
                else r_list[cur_idx] <= r_key;
            end
            CMD_REM_STEP: begin
                if (r_found) r_list[SW'(r_ia - 1'b1)] <= r_list[a_idx];
            end
            default: ;
        endcase
    end

    // Request latch and counters; refusal is decided from the tables at acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req   <= REQ_POLL;
            r_ok    <= 1'b1;
            r_ia    <= '0;
            r_ib    <= '0;
            r_steps <= '0;
            r_nfire <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (i_cmd)
                CMD_ACCEPT: begin
                    r_req   <= i_tuser;
                    r_now   <= i_tdata[31:0];
                    r_sl    <= i_tdata[35:32];
                    r_ival  <= i_tdata[52:36];
                    // wifi, ntp, paused, ota, then flags loop, wifi, ntp, upload.
                    r_bits  <= {i_tdata[59], i_tdata[58], i_tdata[57], i_tdata[60],
                                i_tdata[56:53]};
                    r_ok    <= !((i_tuser == REQ_REG && r_used >= SLOTS_C)
                              || (i_tuser == REQ_SET
                                  && (({28'd0, i_tdata[35:32]} >= 32'(r_used))
                                      || ({28'd0, i_tdata[35:32]} >= 32'(SLOTS)))));
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_steps <= '0;
                    r_nfire <= '0;
                    r_found <= 1'b0;
                end
                CMD_REG: r_ia <= CW'(1);
                CMD_SET: begin
                    r_ia <= o_st.rem_need ? '0 : CW'(1);
                end
                CMD_WALK_STEP: begin
                    r_steps <= r_steps + 1'b1;
                    if (!gated) r_nfire <= r_nfire + 1'b1;
                    r_ib <= r_ia;
                end
                CMD_BUB_STEP: begin
                    if (o_st.bub_swap) r_ib <= r_ib + 1'b1;
                    else if (r_ib == r_ia) r_ia <= r_ia + 1'b1;
                end
                CMD_SORT_KEY: begin
                    r_key    <= r_list[a_idx];
                    r_keydue <= r_due[r_list[a_idx]];
                    r_ib     <= r_ia;
                end
                CMD_SORT_STEP: begin
                    if (o_st.ins_shift) r_ib <= r_ib - 1'b1;
                    else r_ia <= r_ia + 1'b1;
                end
                CMD_REM_STEP: begin
                    if (!r_found && r_list[a_idx] == sl_idx) r_found <= 1'b1;
                    r_ia <= r_ia + 1'b1;
                end
                CMD_REM_END:   r_ia <= CW'(1);
                CMD_WAKE_STEP: r_ia <= r_ia + 1'b1;
                default: ;
            endcase
        end
    end

    // Output register: a fire item during the walk, a status item at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd == CMD_WALK_STEP && !gated) begin
                r_ovalid <= 1'b1;
                r_oslot  <= 4'(front);
                r_ook    <= 1'b1;
                r_owake  <= '0;
                r_okind  <= 1'b0;
            end else if (i_cmd == CMD_STATUS) begin
                r_ovalid <= 1'b1;
                r_oslot  <= '0;
                r_ook    <= r_ok;
                r_owake  <= r_wake;
                r_okind  <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {3'd0, r_owake, r_ook, r_oslot};
    assign o_tuser  = r_okind;
    assign o_tlast  = r_okind;

    a_len_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= r_used) else $error("due list longer than slot count");
    a_used_le_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SLOTS_C) else $error("slot count beyond table size");
    a_fire_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= SLOTS_C) else $error("too many fire items in one poll");

endmodule

// ===== test/tb_due_order_periodic_scheduler.sv =====
// Self-checking testbench for the periodic slot scheduler, with its own model and scoreboard.
module tb_due_order_periodic_scheduler
    import dops_pkg::*;
;

    localparam int NSLOT = 16;

    // Input item of one request.
    typedef struct {
        logic [1:0]  req;
        logic [31:0] now;
        logic [3:0]  slot;
        logic [16:0] interval;
        logic        wifi_ok, ntp_ok, paused, ota;
        logic        n_wifi, n_ntp, upload, loop_en;
    } t_req;

    // One result transaction.
    typedef struct {
        logic        kind;
        logic [3:0]  fired;
        logic        ok;
        logic [31:0] wake;
        logic        last;
    } t_res;

    // Scoreboard: a model of the slot tables and a queue of expected results.
    class sched_scoreboard;
        logic [15:0] period [NSLOT];
        logic [31:0] last_run [NSLOT];
        logic [31:0] due [NSLOT];
        logic [3:0]  flags [NSLOT];
        logic [3:0]  order [NSLOT];
        int          order_len;
        int          used;
        logic [31:0] wake;
        t_res        pending [$];
        int          errors;

        function void clear();
            for (int i = 0; i < NSLOT; i++) begin
                period[i] = '0; last_run[i] = '0; due[i] = '0; flags[i] = '0; order[i] = '0;
            end
            order_len = 0; used = 0; wake = '0; errors = 0;
            pending.delete();
        endfunction

        function logic later(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return (d != 0) && !d[31];
        endfunction

        function logic earlier(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d[31];
        endfunction

        function void resort();
            logic [3:0] key;
            int b;
            for (int a = 1; a < order_len; a++) begin
                key = order[a];
                b = a;
                while (b > 0 && later(due[order[b-1]], due[key])) begin
                    order[b] = order[b-1];
                    b--;
                end
                order[b] = key;
            end
        endfunction

        function void push(logic kind, logic [3:0] s, logic ok, logic [31:0] w);
            t_res r;
            r.kind = kind; r.fired = s; r.ok = ok; r.wake = w; r.last = kind;
            pending.push_back(r);
        endfunction

        function void poll(t_req q);
            int k, steps, fires, cur;
            logic [3:0] s, tmp;
            logic [31:0] fallback, nxt;
            k = 0; steps = 0; fires = 0;
            fallback = q.now + WAKE_CAP;
            if (earlier(q.now, wake)) return;
            if (q.ota) begin
                wake = q.now;
                return;
            end
            while (k < order_len && steps < 4 * NSLOT && fires < NSLOT) begin
                s = order[k];
                if (earlier(q.now, due[s])) break;
                steps++;
                if ((flags[s][FLAG_WIFI] && !q.wifi_ok) || (flags[s][FLAG_NTP] && !q.ntp_ok)
                    || (q.paused && flags[s][FLAG_UPLOAD])) begin
                    due[s] = q.now + DEFER_MS;
                end else begin
                    last_run[s] = q.now;
                    push(1'b0, s, 1'b1, 32'd0);
                    fires++;
                    due[s] = q.now + {16'd0, period[s]};
                end
                cur = k;
                while (cur + 1 < order_len && later(due[order[cur]], due[order[cur+1]])) begin
                    tmp = order[cur]; order[cur] = order[cur+1]; order[cur+1] = tmp;
                    cur++;
                end
                if (cur == k) k++;
            end
            nxt = (order_len > 0) ? due[order[0]] : fallback;
            if (later(nxt, fallback)) nxt = fallback;
            wake = nxt;
        endfunction

        // Note an accepted request and queue the results it causes.
        function void note_request(t_req q);
            logic        neg, was, ok;
            logic [15:0] mag;
            int          i;
            neg = q.interval[16];
            mag = neg ? 16'd0 : q.interval[15:0];
            ok = 1'b1;
            case (q.req)
                REQ_POLL: poll(q);
                REQ_REG: begin
                    if (used >= NSLOT) begin
                        ok = 1'b0;
                    end else begin
                        i = used++;
                        period[i] = mag; last_run[i] = '0; due[i] = '0;
                        flags[i] = {q.upload, q.n_ntp, q.n_wifi, q.loop_en};
                        if (q.loop_en && order_len < NSLOT) begin
                            order[order_len++] = 4'(i);
                            resort();
                        end
                        wake = q.now;
                    end
                end
                REQ_SET: begin
                    if (q.slot >= used) begin
                        ok = 1'b0;
                    end else begin
                        was = flags[q.slot][FLAG_LOOP];
                        if (!neg) begin
                            flags[q.slot][FLAG_LOOP] = 1'b1;
                            period[q.slot] = mag;
                            due[q.slot] = last_run[q.slot] + {16'd0, mag};
                        end else begin
                            flags[q.slot][FLAG_LOOP] = 1'b0;
                        end
                        if (was && neg) begin
                            for (int a = 0; a < order_len; a++) begin
                                if (order[a] == q.slot) begin
                                    for (int b = a; b + 1 < order_len; b++)
                                        order[b] = order[b+1];
                                    order_len--;
                                    break;
                                end
                            end
                        end else if (!was && !neg && order_len < NSLOT) begin
                            order[order_len++] = q.slot;
                        end
                        resort();
                        wake = q.now;
                    end
                end
                default: begin
                    for (int a = 0; a < order_len; a++) due[order[a]] = q.now;
                    wake = q.now;
                end
            endcase
            push(1'b1, 4'd0, ok, wake);
        endfunction

        // Compare one result transaction with the oldest expectation.
        function void check_result(t_res r);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d slot=%0d ok=%0d wake=%h last=%0d",
                         $time, r.kind, r.fired, r.ok, r.wake, r.last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.kind !== e.kind || r.fired !== e.fired || r.ok !== e.ok
                || r.wake !== e.wake || r.last !== e.last) begin
                $display("%0t: mismatch expected kind=%0d slot=%0d ok=%0d wake=%h last=%0d",
                         $time, e.kind, e.fired, e.ok, e.wake, e.last);
                $display("%0t:          actual   kind=%0d slot=%0d ok=%0d wake=%h last=%0d",
                         $time, r.kind, r.fired, r.ok, r.wake, r.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    sched_scoreboard sb;
    int              idle_pct;
    logic [31:0]     clock_ms;

    due_order_periodic_scheduler #(.SLOTS(NSLOT)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // Receiver: random back-pressure, each transaction checked at the edge it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_res r;
            r.kind = m_axis_tuser; r.fired = m_axis_tdata[3:0]; r.ok = m_axis_tdata[4];
            r.wake = m_axis_tdata[36:5]; r.last = m_axis_tlast;
            sb.check_result(r);
        end
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Send one request, with random idle cycles before it; valid stays up until the next
    // request or an idle cycle replaces it, as the block is busy after acceptance anyway.
    task automatic send(t_req q);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {3'd0, q.loop_en, q.upload, q.n_ntp, q.n_wifi, q.ota, q.paused,
                         q.ntp_ok, q.wifi_ok, q.interval, q.slot, q.now};
        s_axis_tuser <= q.req;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(q);
    endtask

    function automatic t_req mk(logic [1:0] req, logic [31:0] now);
        t_req q;
        q.req = req; q.now = now; q.slot = '0; q.interval = '0;
        q.wifi_ok = 1'b1; q.ntp_ok = 1'b1; q.paused = 1'b0; q.ota = 1'b0;
        q.n_wifi = 1'b0; q.n_ntp = 1'b0; q.upload = 1'b0; q.loop_en = 1'b1;
        return q;
    endfunction

    function automatic t_req rand_req(logic [31:0] now);
        t_req q;
        int   p;
        q = mk(REQ_POLL, now);
        p = $urandom_range(99);
        q.req = (p < 60) ? REQ_POLL : (p < 72) ? REQ_REG : (p < 94) ? REQ_SET : REQ_WAKE;
        q.slot = 4'($urandom_range(15));
        case ($urandom_range(5))
            0: q.interval = 17'h1FFFF;
            1: q.interval = 17'(32'h10000 | $urandom_range(16'hFFFF));
            2: q.interval = 17'h0FFFF;
            3: q.interval = '0;
            default: q.interval = 17'($urandom_range(20));
        endcase
        q.wifi_ok = ($urandom_range(9) != 0); q.ntp_ok = ($urandom_range(9) != 0);
        q.paused = ($urandom_range(7) == 0); q.ota = ($urandom_range(19) == 0);
        q.n_wifi = 1'($urandom); q.n_ntp = 1'($urandom); q.upload = 1'($urandom);
        q.loop_en = ($urandom_range(4) != 0);
        return q;
    endfunction

    // Stop sending and wait until every expected result has come.
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        t_req q;
        sb = new();
        sb.clear();
        idle_pct = 9;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_POLL;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, refused set, registrations with every flag, extremes.
        send(mk(REQ_POLL, 32'd0));
        q = mk(REQ_SET, 32'd5); q.slot = 4'd15; send(q);
        q = mk(REQ_REG, 32'd10); q.interval = 17'h0FFFF; send(q);
        q = mk(REQ_REG, 32'd10); q.interval = 17'h1FFFF; q.n_wifi = 1'b1; send(q);
        q = mk(REQ_REG, 32'd10); q.interval = 17'd0; q.n_ntp = 1'b1; send(q);
        q = mk(REQ_REG, 32'd10); q.interval = 17'd3; q.upload = 1'b1; send(q);
        q = mk(REQ_REG, 32'd10); q.loop_en = 1'b0; q.interval = 17'd7; send(q);
        q = mk(REQ_POLL, 32'd20); q.wifi_ok = 1'b0; q.ntp_ok = 1'b0; q.paused = 1'b1; send(q);
        send(mk(REQ_POLL, 32'd21));
        send(mk(REQ_POLL, 32'd0));
        q = mk(REQ_POLL, 32'd30); q.ota = 1'b1; send(q);
        q = mk(REQ_SET, 32'd31); q.slot = 4'd4; q.interval = 17'd2; send(q);
        q = mk(REQ_SET, 32'd32); q.slot = 4'd1; q.interval = 17'h1FFFF; send(q);
        send(mk(REQ_WAKE, 32'hFFFF_FFF0));
        send(mk(REQ_POLL, 32'hFFFF_FFF0));
        send(mk(REQ_POLL, 32'h0000_0010));
        q = mk(REQ_SET, 32'd40); q.slot = 4'd2; q.interval = 17'd5; send(q);
        send(mk(REQ_POLL, 32'hFFFF_FFFF));

        // Hold off until every result has come.
        drain();

        // Random part, first with no idling at all, then the usual rate.
        clock_ms = 32'hFFFF_F000;
        idle_pct = 0;
        for (int n = 0; n < 400; n++) begin
            if (n == 80) idle_pct = 9;
            if (n == 200) drain();
            clock_ms = clock_ms + $urandom_range(3);
            if ($urandom_range(29) == 0) clock_ms = $urandom;
            send(rand_req(clock_ms));
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.pending.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dops_pkg.sv
rtl/core/dops_ctrl.sv
rtl/core/dops_dp.sv
rtl/core/due_order_periodic_scheduler.sv
test/tb_due_order_periodic_scheduler.sv
